FILE: rtl/hdc_pkg.sv
// shared types and constants of the humidity / temperature frame decoder
// no dependencies
`default_nettype none

package hdc_pkg;

  // measurement kinds
  localparam logic [1:0] CMD_TEMP  = 2'd0;
  localparam logic [1:0] CMD_HUMID = 2'd1;

  // crc-8, polynomial x^8 + x^5 + x^4 + 1, init zero
  localparam logic [7:0] CRC_POLY = 8'h31;

  // status bits in the low data byte
  localparam logic [15:0] STATUS_MASK = 16'hFFFC;

  // conversion coefficients, scaled by 100 (hundredths); offsets scaled by 100 * 65536
  localparam logic [14:0] TEMP_COEF  = 15'd17572;
  localparam logic [14:0] HUMID_COEF = 15'd12500;
  localparam logic [30:0] TEMP_OFFS  = 31'd4685 * 31'd65536;
  localparam logic [30:0] HUMID_OFFS = 31'd600 * 31'd65536;

  // ceil(2^19 / 10), exact quotient by ten for 14-bit operands
  localparam logic [15:0] RECIP10 = 16'd52429;

  localparam logic [10:0]        RH_LIMIT = 11'd999;
  localparam logic signed [11:0] SENTINEL = 12'sh7FF;

  // frame check outcome
  typedef struct packed {
    logic good;
    logic humid;
  } hdc_chk_t;

endpackage

`default_nettype wire

FILE: rtl/hdc_frame_check.sv
// frame validity check: kind, bus acknowledge, all-zero frame and crc-8
// depends on hdc_pkg
`default_nettype none

module hdc_frame_check
  import hdc_pkg::*;
(
  input  wire logic [1:0] cmd,
  input  wire logic       bus_ok,
  input  wire logic [7:0] data_high,
  input  wire logic [7:0] data_low,
  input  wire logic [7:0] crc_byte,
  output hdc_chk_t        chk
);

  // one byte into the crc register, msb first
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] b);
    logic [7:0] c;
    c = crc_in ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  logic [7:0] crc_calc;
  logic       kind_ok;
  logic       all_zero;

  assign crc_calc = crc8_byte(crc8_byte(8'h00, data_high), data_low);
  assign kind_ok  = (cmd == CMD_TEMP) || (cmd == CMD_HUMID);
  assign all_zero = (data_high == 8'h00) && (data_low == 8'h00) && (crc_byte == 8'h00);

  assign chk.good  = kind_ok && bus_ok && !all_zero && (crc_calc == crc_byte);
  assign chk.humid = (cmd == CMD_HUMID);

endmodule

`default_nettype wire

FILE: rtl/hdc_scale.sv
// two-stage conversion of a masked reading to tenths, with clamp and sentinel
// depends on hdc_pkg
`default_nettype none

module hdc_scale
  import hdc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_vld,
  input  wire hdc_chk_t           in_chk,
  input  wire logic [15:0]        in_raw,
  output logic                    out_vld,
  output logic signed [11:0]      out_val,
  output logic                    out_good
);

  // stage a: scaled product minus offset, sign and magnitude / 65536
  logic [14:0] coef;
  logic [30:0] offs;
  logic [30:0] prod;
  logic        neg;
  logic [30:0] mag;

  assign coef = in_chk.humid ? HUMID_COEF : TEMP_COEF;
  assign offs = in_chk.humid ? HUMID_OFFS : TEMP_OFFS;
  assign prod = in_raw * coef;
  assign neg  = prod < offs;
  assign mag  = neg ? (offs - prod) : (prod - offs);

  logic        a_vld_r;
  hdc_chk_t    a_chk_r;
  logic        a_neg_r;
  logic [13:0] a_q1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= in_vld;
    end
    a_chk_r <= in_chk;
    a_neg_r <= neg;
    a_q1_r  <= mag[29:16];
  end

  // stage b: divide by ten, restore sign, clamp humidity, sentinel for failed frames
  logic [29:0]        qm;
  logic [10:0]        q;
  logic signed [11:0] val_nxt;
  logic signed [11:0] val_r;
  logic               good_r;
  logic               vld_r;

  assign qm = a_q1_r * RECIP10;
  assign q  = qm[29:19];

  always_comb begin
    if (!a_chk_r.good) begin
      val_nxt = SENTINEL;
    end else if (a_chk_r.humid && !a_neg_r && (q >= RH_LIMIT)) begin
      val_nxt = $signed({1'b0, RH_LIMIT});
    end else if (a_neg_r) begin
      val_nxt = -$signed({1'b0, q});
    end else begin
      val_nxt = $signed({1'b0, q});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= a_vld_r;
    end
    val_r  <= val_nxt;
    good_r <= a_chk_r.good;
  end

  assign out_vld  = vld_r;
  assign out_val  = val_r;
  assign out_good = good_r;

endmodule

`default_nettype wire

FILE: rtl/humidity_temp_frame_decoder.sv
// top level of the humidity / temperature frame decoder
// depends on hdc_pkg, hdc_frame_check and hdc_scale
//
//  channel   ports                                              handshake
//  input     in_cmd in_bus_ok in_data_high in_data_low          start & !busy
//            in_crc_byte
//  result    out_value out_ok                                   out_valid, one cycle
//
// one word accepted every cycle; busy is never raised
// a result passes three registers after its word: input register, product
//   register (crc check and scaled product), result register (divide by ten)
// the 16x15 product and the reciprocal multiply set the stage depths
// synchronous active-low reset clears the valid bits of all three stages
// the receiver cannot stall; out_valid is a strobe for a single cycle
`default_nettype none

module humidity_temp_frame_decoder
  import hdc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         in_cmd,
  input  wire logic               in_bus_ok,
  input  wire logic [7:0]         in_data_high,
  input  wire logic [7:0]         in_data_low,
  input  wire logic [7:0]         in_crc_byte,
  output logic                    out_valid,
  output logic signed [11:0]      out_value,
  output logic                    out_ok
);

  // a fully pipelined datapath never needs to hold off the sender
  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // input register, payload needs no reset
  logic       in_vld_r;
  logic [1:0] cmd_r;
  logic       bus_ok_r;
  logic [7:0] dh_r;
  logic [7:0] dl_r;
  logic [7:0] cb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= accept;
    end
    cmd_r    <= in_cmd;
    bus_ok_r <= in_bus_ok;
    dh_r     <= in_data_high;
    dl_r     <= in_data_low;
    cb_r     <= in_crc_byte;
  end

  // kind, acknowledge, zero frame and crc checks
  hdc_chk_t chk;

  hdc_frame_check u_check (
    .cmd       (cmd_r),
    .bus_ok    (bus_ok_r),
    .data_high (dh_r),
    .data_low  (dl_r),
    .crc_byte  (cb_r),
    .chk       (chk)
  );

  // reading with the two status bits cleared
  logic [15:0] raw;
  assign raw = {dh_r, dl_r} & STATUS_MASK;

  // conversion pipeline, output registers live inside
  hdc_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (in_vld_r),
    .in_chk   (chk),
    .in_raw   (raw),
    .out_vld  (out_valid),
    .out_val  (out_value),
    .out_good (out_ok)
  );

`ifndef SYNTH
  // every accepted word gives a result strobe
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##3 out_valid)
    else $error("accepted word produced no result");

  // no strobe without an accepted word
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |-> ##3 !out_valid)
    else $error("result strobe without accepted word");

  // rejected frames carry the sentinel
  a_sentinel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ok) |-> (out_value == SENTINEL))
    else $error("rejected frame without sentinel");

  // converted readings stay inside the physical range
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ok) |-> ((out_value >= -12'sd468) && (out_value <= 12'sd1288)))
    else $error("converted value out of range");
`endif

endmodule

`default_nettype wire
